FILE: design/meter_obis_record_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the measurement record parser
// Implication checks, same cycle and next cycle, under synchronous reset.
// ----------------------------------------------------------------------------
`ifndef METER_OBIS_RECORD_PARSER_MACROS_SVH
`define METER_OBIS_RECORD_PARSER_MACROS_SVH

// antecedent and consequent in the same cycle
`define MOPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("record parser check failed");

// consequent in the cycle after the antecedent
`define MOPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("record parser check failed");

`endif

FILE: design/mopr_pkg.sv
// ----------------------------------------------------------------------------
// Measurement record parser package
// Beat types, quantity codes and record layout constants.
// ----------------------------------------------------------------------------
package mopr_pkg;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]         quantity;
      logic signed [63:0] measured_value;
      logic               end_of_datagram;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      QTY_NONE            = 5'd0,
      QTY_POWER_TOTAL     = 5'd1,
      QTY_POWER_A         = 5'd2,
      QTY_POWER_B         = 5'd3,
      QTY_POWER_C         = 5'd4,
      QTY_CURRENT_A       = 5'd5,
      QTY_CURRENT_B       = 5'd6,
      QTY_CURRENT_C       = 5'd7,
      QTY_VOLTAGE_A       = 5'd8,
      QTY_VOLTAGE_B       = 5'd9,
      QTY_VOLTAGE_C       = 5'd10,
      QTY_ENERGY_IN_TOTAL = 5'd11,
      QTY_ENERGY_OUT_TOTAL= 5'd12,
      QTY_ENERGY_IN_A     = 5'd13,
      QTY_ENERGY_IN_B     = 5'd14,
      QTY_ENERGY_IN_C     = 5'd15,
      QTY_ENERGY_OUT_A    = 5'd16,
      QTY_ENERGY_OUT_B    = 5'd17,
      QTY_ENERGY_OUT_C    = 5'd18,
      QTY_VERSION         = 5'd19
   } quantity_type;

   localparam logic [3:0]  SKIP_BYTES   = 4'd10;
   localparam logic [3:0]  HEADER_BYTES = 4'd4;
   localparam logic [3:0]  SHORT_BYTES  = 4'd4;
   localparam logic [3:0]  LONG_BYTES   = 4'd8;
   localparam logic [3:0]  NO_BYTES     = 4'd0;
   localparam logic [3:0]  MAX_POSITION = 4'd12;
   localparam logic [7:0]  TYPE_SHORT   = 8'd4;
   localparam logic [7:0]  TYPE_LONG    = 8'd8;
   localparam logic [31:0] VERSION_ID   = 32'h9000_0000;

   localparam logic [7:0] IDX_IMPORT_TOTAL = 8'd1;
   localparam logic [7:0] IDX_EXPORT_TOTAL = 8'd2;
   localparam logic [7:0] IDX_IMPORT_A     = 8'd21;
   localparam logic [7:0] IDX_EXPORT_A     = 8'd22;
   localparam logic [7:0] IDX_CURRENT_A    = 8'd31;
   localparam logic [7:0] IDX_VOLTAGE_A    = 8'd32;
   localparam logic [7:0] IDX_IMPORT_B     = 8'd41;
   localparam logic [7:0] IDX_EXPORT_B     = 8'd42;
   localparam logic [7:0] IDX_CURRENT_B    = 8'd51;
   localparam logic [7:0] IDX_VOLTAGE_B    = 8'd52;
   localparam logic [7:0] IDX_IMPORT_C     = 8'd61;
   localparam logic [7:0] IDX_EXPORT_C     = 8'd62;
   localparam logic [7:0] IDX_CURRENT_C    = 8'd71;
   localparam logic [7:0] IDX_VOLTAGE_C    = 8'd72;

endpackage

FILE: design/meter_obis_record_parser.sv
// Timing: an accepted beat's result, if any, is registered into the result
// register when the beat advances. Throughput: one payload byte per cycle
// unless rsp_stall holds the result; the input register and the result
// register each hold one beat, so the byte parse runs back to back.
// Reset: synchronous; clears the skip count, record position, identifier,
// accumulator and both valid flags; a final byte clears all but the flags.
// ----------------------------------------------------------------------------
// Measurement record parser
// Skips the payload prefix, gathers record headers and big-endian values,
// and maps known records to quantity codes with signed values, export power negated.
// ----------------------------------------------------------------------------
`include "meter_obis_record_parser_macros.svh"

module meter_obis_record_parser
   import mopr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            hold_valid_ff, hold_valid_in;
   req_payload_type hold_beat_ff, hold_beat_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_beat_ff, rsp_beat_in;

   logic [3:0]  pre_ff, pre_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] id_ff, id_in;
   logic [63:0] acc_ff, acc_in;

   logic        advance;
   logic        complete;
   logic [3:0]  pos_next;
   logic [7:0]  rec_index;
   logic [7:0]  rec_type;
   logic [63:0] short_val;
   logic [63:0] short_neg;
   logic        short_nz;
   logic        long_nz;
   quantity_type qty;
   logic [63:0] val;

   function automatic logic [3:0] value_length(input logic [31:0] id);
      logic [3:0] len;
      priority if (id[15:8] == TYPE_SHORT) begin
         len = SHORT_BYTES;
      end else if (id[15:8] == TYPE_LONG) begin
         len = LONG_BYTES;
      end else if (id == VERSION_ID) begin
         len = SHORT_BYTES;
      end else begin
         len = NO_BYTES;
      end
      return len;
   endfunction

   assign advance   = hold_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = hold_valid_ff && !advance;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_beat_in  = hold_beat_ff;
      if (!req_stall) begin
         hold_valid_in = req_valid;
         hold_beat_in  = req_payload;
      end
   end

   // advance the record parse
   always_comb begin
      pre_in   = pre_ff;
      pos_in   = pos_ff;
      id_in    = id_ff;
      acc_in   = acc_ff;
      complete = 1'b0;
      pos_next = pos_ff + 4'd1;
      if (pre_ff < SKIP_BYTES) begin
         pre_in = pre_ff + 4'd1;
      end else if (pos_ff < HEADER_BYTES) begin
         id_in  = {id_ff[23:0], hold_beat_ff.payload_byte};
         pos_in = pos_next;
         acc_in = '0;
         if (pos_next == HEADER_BYTES && value_length(id_in) == NO_BYTES) begin
            pos_in = '0;
         end
      end else begin
         acc_in = {acc_ff[55:0], hold_beat_ff.payload_byte};
         pos_in = pos_next;
         if (pos_next >= HEADER_BYTES + value_length(id_ff)) begin
            complete = 1'b1;
            pos_in   = '0;
         end
      end
   end

   assign rec_index = id_ff[23:16];
   assign rec_type  = id_ff[15:8];
   assign short_val = {{32{acc_in[31]}}, acc_in[31:0]};
   assign short_neg = 64'd0 - short_val;
   assign short_nz  = |acc_in[31:0];
   assign long_nz   = |acc_in;

   always_comb begin
      qty = QTY_NONE;
      val = '0;
      priority if (rec_type == TYPE_SHORT) begin
         unique case (rec_index)
            IDX_IMPORT_TOTAL: if (short_nz) begin qty = QTY_POWER_TOTAL; val = short_val; end
            IDX_IMPORT_A:     if (short_nz) begin qty = QTY_POWER_A;     val = short_val; end
            IDX_IMPORT_B:     if (short_nz) begin qty = QTY_POWER_B;     val = short_val; end
            IDX_IMPORT_C:     if (short_nz) begin qty = QTY_POWER_C;     val = short_val; end
            IDX_EXPORT_TOTAL: if (short_nz) begin qty = QTY_POWER_TOTAL; val = short_neg; end
            IDX_EXPORT_A:     if (short_nz) begin qty = QTY_POWER_A;     val = short_neg; end
            IDX_EXPORT_B:     if (short_nz) begin qty = QTY_POWER_B;     val = short_neg; end
            IDX_EXPORT_C:     if (short_nz) begin qty = QTY_POWER_C;     val = short_neg; end
            IDX_CURRENT_A: begin qty = QTY_CURRENT_A; val = short_val; end
            IDX_CURRENT_B: begin qty = QTY_CURRENT_B; val = short_val; end
            IDX_CURRENT_C: begin qty = QTY_CURRENT_C; val = short_val; end
            IDX_VOLTAGE_A: begin qty = QTY_VOLTAGE_A; val = short_val; end
            IDX_VOLTAGE_B: begin qty = QTY_VOLTAGE_B; val = short_val; end
            IDX_VOLTAGE_C: begin qty = QTY_VOLTAGE_C; val = short_val; end
            default: ;
         endcase
      end else if (rec_type == TYPE_LONG) begin
         if (long_nz) begin
            val = acc_in;
            unique case (rec_index)
               IDX_IMPORT_TOTAL: qty = QTY_ENERGY_IN_TOTAL;
               IDX_EXPORT_TOTAL: qty = QTY_ENERGY_OUT_TOTAL;
               IDX_IMPORT_A:     qty = QTY_ENERGY_IN_A;
               IDX_IMPORT_B:     qty = QTY_ENERGY_IN_B;
               IDX_IMPORT_C:     qty = QTY_ENERGY_IN_C;
               IDX_EXPORT_A:     qty = QTY_ENERGY_OUT_A;
               IDX_EXPORT_B:     qty = QTY_ENERGY_OUT_B;
               IDX_EXPORT_C:     qty = QTY_ENERGY_OUT_C;
               default:          qty = QTY_NONE;
            endcase
         end
      end else if (id_ff == VERSION_ID) begin
         qty = QTY_VERSION;
         val = {32'd0, acc_in[31:0]};
      end else begin
         qty = QTY_NONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_beat_in  = rsp_beat_ff;
      if (advance) begin
         rsp_valid_in = (complete && qty != QTY_NONE) || hold_beat_ff.last_byte;
         rsp_beat_in.quantity        = (complete && qty != QTY_NONE) ? qty : QTY_NONE;
         rsp_beat_in.measured_value  = (complete && qty != QTY_NONE) ? val : 64'd0;
         rsp_beat_in.end_of_datagram = hold_beat_ff.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pre_ff        <= '0;
         pos_ff        <= '0;
         id_ff         <= '0;
         acc_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            if (hold_beat_ff.last_byte) begin
               pre_ff <= '0;
               pos_ff <= '0;
               id_ff  <= '0;
               acc_ff <= '0;
            end else begin
               pre_ff <= pre_in;
               pos_ff <= pos_in;
               id_ff  <= id_in;
               acc_ff <= acc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_beat_ff <= hold_beat_in;
      rsp_beat_ff  <= rsp_beat_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_beat_ff;

   `MOPR_ASSERT_NOW(a_mid_result_has_code, clock, reset,
      rsp_valid_ff && !rsp_beat_ff.end_of_datagram, rsp_beat_ff.quantity != QTY_NONE)
   `MOPR_ASSERT_NOW(a_empty_result_is_zero, clock, reset,
      rsp_valid_ff && rsp_beat_ff.quantity == QTY_NONE, rsp_beat_ff.measured_value == 64'sd0)
   `MOPR_ASSERT_NEXT(a_last_restarts, clock, reset,
      advance && hold_beat_ff.last_byte, pre_ff == 4'd0 && pos_ff == 4'd0)
   `MOPR_ASSERT_NOW(a_counts_bounded, clock, reset,
      1'b1, pre_ff <= SKIP_BYTES && pos_ff <= MAX_POSITION)

endmodule
